// File: rtl/core/circle_ring_vertices_macros.svh
// ---------------------------------------------------------------------------
// circle_ring_vertices_macros.svh
// Assertion macros for the ring vertex generator.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_RING_VERTICES_MACROS_SVH
`define CIRCLE_RING_VERTICES_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define CRV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crv: same-cycle check failed");
// next-cycle implication, sampled on clk, off during reset
`define CRV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crv: next-cycle check failed");
`else
`define CRV_ASSERT_IMP(label, ante, cons)
`define CRV_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/core/crv_pkg.sv
// ---------------------------------------------------------------------------
// crv_pkg
// Types, constants and helper functions of the ring vertex generator.
// ---------------------------------------------------------------------------
`default_nettype none

package crv_pkg;

  localparam logic [6:0] MAX_SEGMENTS = 7'd64;
  localparam logic [6:0] MIN_SEGMENTS = 7'd3;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic [31:0] NINE_TENTHS = 32'd966367642;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  // one ring handed from the setup side to the point side
  typedef struct packed {
    logic [2:0][31:0] ctr;
    logic [30:0]      radius;
    logic [6:0]       segs;
    logic [2:0][31:0] u;
    logic [2:0][31:0] v;
    logic [30:0]      step_q;
    logic [6:0]       step_rem;
  } frame_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SQ, F_SQRT, F_DINIT, F_DIV, F_NEXT, F_CROSS, F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {B_IDLE, B_ROT, B_MAC, B_OUT} back_state_t;

  typedef enum logic [1:0] {PASS_N, PASS_U, PASS_V, PASS_PHASE} pass_t;

  // add half an LSB of Q30 and floor
  function automatic logic signed [37:0] round_q30(input logic signed [67:0] val);
    logic signed [67:0] t;
    t = val + 68'sd536870912;
    return 38'(t >>> 30);
  endfunction

  // arctangent of 2^-k in units of 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] a;
    case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/crv_ifs.sv
// ---------------------------------------------------------------------------
// crv_ifs
// Request and point channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface crv_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  logic [30:0]        radius;
  logic [6:0]         segment_count;
  modport source (output valid, center_x, center_y, center_z, normal_x, normal_y,
                  normal_z, radius, segment_count, input ready);
  modport sink (input valid, center_x, center_y, center_z, normal_x, normal_y,
                normal_z, radius, segment_count, output ready);
endinterface

interface crv_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [5:0]         point_index;
  logic               last_point;
  modport source (output valid, point_x, point_y, point_z, point_index, last_point,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, point_index, last_point,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/crv_front.sv
// ---------------------------------------------------------------------------
// crv_front
// Ring setup: clamps the count, normalizes the normal, builds u and v,
// and works out the per-point phase step.
// ---------------------------------------------------------------------------
`default_nettype none

module crv_front #(
  parameter logic [6:0] MAX_SEGMENTS = crv_pkg::MAX_SEGMENTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  crv_req_if.sink          req,
  output crv_pkg::frame_t  frm,
  output logic             frm_valid,
  input  wire logic        frm_full
);

  crv_pkg::front_state_t state_r, state_nxt;
  crv_pkg::pass_t        pass_r;
  logic [2:0]            cnt_r;
  logic [1:0]            k_r;
  logic [4:0]            step_r;
  logic signed [31:0]    ctr_r [3];
  logic [30:0]           radius_r;
  logic [6:0]            segs_r;
  logic signed [33:0]    vec_r [3];
  logic signed [31:0]    n_r [3];
  logic signed [31:0]    u_r [3];
  logic signed [31:0]    v_r [3];
  logic [63:0]           sum_r;
  logic signed [67:0]    acc_r;
  logic signed [67:0]    prod_r;
  logic [63:0]           sq_s_r, sq_root_r, sq_bit_r;
  logic [31:0]           len_r;
  logic [61:0]           divnum_r;
  logic [31:0]           rem_r;
  logic [30:0]           quo_r;
  logic [30:0]           stq_r;
  logic [6:0]            strem_r;

  logic signed [33:0] mul_a, mul_b;
  logic [31:0]        mag_sq, mag_div;
  logic [63:0]        sq_rb;
  logic               sq_ge;
  logic [31:0]        den;
  logic [32:0]        div_tr;
  logic               div_ge;
  logic [31:0]        div_rem_nxt;
  logic [30:0]        quo_nxt;
  logic signed [31:0] unit_val;
  logic [4:0]         div_idx;
  logic [6:0]         segs_clamped;
  logic signed [33:0] cross_val;

  // clamp a component to 2^31 in magnitude
  function automatic logic [31:0] mag_of(input logic signed [33:0] c);
    logic [33:0] a;
    a = c[33] ? 34'(-c) : 34'(c);
    if (a > 34'h080000000) a = 34'h080000000;
    return a[31:0];
  endfunction

  // count clamp
  always_comb begin
    segs_clamped = req.segment_count;
    if (req.segment_count < crv_pkg::MIN_SEGMENTS) segs_clamped = crv_pkg::MIN_SEGMENTS;
    if (req.segment_count > MAX_SEGMENTS) segs_clamped = MAX_SEGMENTS;
  end

  // shared multiplier operands
  always_comb begin
    mag_sq = 32'd0;
    mul_a  = 34'sd0;
    mul_b  = 34'sd0;
    if (state_r == crv_pkg::F_SQ) begin
      case (cnt_r)
        3'd0: mag_sq = mag_of(vec_r[0]);
        3'd1: mag_sq = mag_of(vec_r[1]);
        3'd2: mag_sq = mag_of(vec_r[2]);
        default: mag_sq = 32'd0;
      endcase
      mul_a = $signed({2'b00, mag_sq});
      mul_b = $signed({2'b00, mag_sq});
    end else if (state_r == crv_pkg::F_CROSS) begin
      case (cnt_r)
        3'd0: begin mul_a = 34'(n_r[1]); mul_b = 34'(u_r[2]); end
        3'd1: begin mul_a = 34'(n_r[2]); mul_b = 34'(u_r[1]); end
        3'd2: begin mul_a = 34'(n_r[2]); mul_b = 34'(u_r[0]); end
        3'd3: begin mul_a = 34'(n_r[0]); mul_b = 34'(u_r[2]); end
        3'd4: begin mul_a = 34'(n_r[0]); mul_b = 34'(u_r[1]); end
        3'd5: begin mul_a = 34'(n_r[1]); mul_b = 34'(u_r[0]); end
        default: begin mul_a = 34'sd0; mul_b = 34'sd0; end
      endcase
    end
  end

  // square root step, divider step
  always_comb begin
    sq_rb       = sq_root_r + sq_bit_r;
    sq_ge       = sq_s_r >= sq_rb;
    mag_div     = mag_of(vec_r[k_r]);
    den         = (pass_r == crv_pkg::PASS_PHASE) ? {25'd0, segs_r} : len_r;
    div_idx     = 5'd30 - step_r;
    div_tr      = {rem_r, divnum_r[{1'b0, div_idx}]};
    div_ge      = div_tr >= {1'b0, den};
    div_rem_nxt = div_ge ? 32'(div_tr - {1'b0, den}) : div_tr[31:0];
    quo_nxt     = {quo_r[29:0], div_ge};
    if (len_r == 32'd0) unit_val = 32'sd0;
    else if (vec_r[k_r][33]) unit_val = -$signed({1'b0, quo_nxt});
    else unit_val = $signed({1'b0, quo_nxt});
    cross_val = 34'(crv_pkg::round_q30(acc_r - prod_r));
  end

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    req.ready = 1'b0;
    frm_valid = 1'b0;
    case (state_r)
      crv_pkg::F_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_nxt = crv_pkg::F_SQ;
      end
      crv_pkg::F_SQ: begin
        if (cnt_r == 3'd3) state_nxt = crv_pkg::F_SQRT;
      end
      crv_pkg::F_SQRT: begin
        if (step_r == 5'd31) state_nxt = crv_pkg::F_DINIT;
      end
      crv_pkg::F_DINIT: state_nxt = crv_pkg::F_DIV;
      crv_pkg::F_DIV: begin
        if (step_r == 5'd30) begin
          if (pass_r == crv_pkg::PASS_PHASE) state_nxt = crv_pkg::F_PUSH;
          else if (k_r == 2'd2) state_nxt = crv_pkg::F_NEXT;
          else state_nxt = crv_pkg::F_DINIT;
        end
      end
      crv_pkg::F_NEXT: begin
        case (pass_r)
          crv_pkg::PASS_N: state_nxt = crv_pkg::F_SQ;
          crv_pkg::PASS_U: state_nxt = crv_pkg::F_CROSS;
          default: state_nxt = crv_pkg::F_DINIT;
        endcase
      end
      crv_pkg::F_CROSS: begin
        if (cnt_r == 3'd6) state_nxt = crv_pkg::F_SQ;
      end
      crv_pkg::F_PUSH: begin
        frm_valid = 1'b1;
        if (!frm_full) state_nxt = crv_pkg::F_IDLE;
      end
      default: state_nxt = crv_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= crv_pkg::F_IDLE;
    else state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      crv_pkg::F_IDLE: begin
        if (req.valid) begin
          ctr_r[0] <= req.center_x;
          ctr_r[1] <= req.center_y;
          ctr_r[2] <= req.center_z;
          vec_r[0] <= 34'(req.normal_x);
          vec_r[1] <= 34'(req.normal_y);
          vec_r[2] <= 34'(req.normal_z);
          radius_r <= req.radius;
          segs_r   <= segs_clamped;
          pass_r   <= crv_pkg::PASS_N;
          cnt_r    <= 3'd0;
          sum_r    <= 64'd0;
        end
      end
      crv_pkg::F_SQ: begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r != 3'd0) sum_r <= sum_r + prod_r[63:0];
        if (cnt_r == 3'd3) begin
          sq_s_r    <= sum_r + prod_r[63:0];
          sq_root_r <= 64'd0;
          sq_bit_r  <= 64'h4000_0000_0000_0000;
          step_r    <= 5'd0;
        end
      end
      crv_pkg::F_SQRT: begin
        // one result bit per cycle
        if (sq_ge) begin
          sq_s_r    <= sq_s_r - sq_rb;
          sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
        end else begin
          sq_root_r <= sq_root_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        step_r   <= step_r + 5'd1;
        if (step_r == 5'd31) begin
          len_r <= sq_ge ? 32'((sq_root_r >> 1) + sq_bit_r) : 32'(sq_root_r >> 1);
          k_r   <= 2'd0;
        end
      end
      crv_pkg::F_DINIT: begin
        if (pass_r == crv_pkg::PASS_PHASE) divnum_r <= 62'd1 << 32;
        else divnum_r <= {mag_div, 30'd0} + 62'(len_r >> 1);
        rem_r  <= (pass_r == crv_pkg::PASS_PHASE) ? 32'd2
                  : {1'b0, 31'(({mag_div, 30'd0} + 62'(len_r >> 1)) >> 31)};
        quo_r  <= 31'd0;
        step_r <= 5'd0;
      end
      crv_pkg::F_DIV: begin
        rem_r  <= div_rem_nxt;
        quo_r  <= quo_nxt;
        step_r <= step_r + 5'd1;
        if (step_r == 5'd30) begin
          k_r <= k_r + 2'd1;
          case (pass_r)
            crv_pkg::PASS_N: n_r[k_r] <= unit_val;
            crv_pkg::PASS_U: u_r[k_r] <= unit_val;
            crv_pkg::PASS_V: v_r[k_r] <= unit_val;
            default: begin
              stq_r   <= quo_nxt;
              strem_r <= div_rem_nxt[6:0];
            end
          endcase
        end
      end
      crv_pkg::F_NEXT: begin
        cnt_r <= 3'd0;
        sum_r <= 64'd0;
        case (pass_r)
          crv_pkg::PASS_N: begin
            // helper axis cross product is exact: no multiply needed
            pass_r <= crv_pkg::PASS_U;
            if (mag_of(34'(n_r[0])) < crv_pkg::NINE_TENTHS) begin
              vec_r[0] <= 34'sd0;
              vec_r[1] <= 34'(n_r[2]);
              vec_r[2] <= -34'(n_r[1]);
            end else begin
              vec_r[0] <= -34'(n_r[2]);
              vec_r[1] <= 34'sd0;
              vec_r[2] <= 34'(n_r[0]);
            end
          end
          crv_pkg::PASS_U: pass_r <= crv_pkg::PASS_U;
          default: pass_r <= crv_pkg::PASS_PHASE;
        endcase
      end
      crv_pkg::F_CROSS: begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r[0]) acc_r <= prod_r;
        if (cnt_r == 3'd2) vec_r[0] <= cross_val;
        if (cnt_r == 3'd4) vec_r[1] <= cross_val;
        if (cnt_r == 3'd6) begin
          vec_r[2] <= cross_val;
          pass_r   <= crv_pkg::PASS_V;
          cnt_r    <= 3'd0;
          sum_r    <= 64'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // frame to the queue
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      frm.ctr[k] = ctr_r[k];
      frm.u[k]   = u_r[k];
      frm.v[k]   = v_r[k];
    end
    frm.radius   = radius_r;
    frm.segs     = segs_r;
    frm.step_q   = stq_r;
    frm.step_rem = strem_r;
  end

endmodule

`default_nettype wire

// File: rtl/core/crv_queue.sv
// ---------------------------------------------------------------------------
// crv_queue
// Two-entry frame queue between ring setup and point generation.
// ---------------------------------------------------------------------------
`default_nettype none

module crv_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire crv_pkg::frame_t wr_frm,
  input  wire logic            push,
  output logic                 full,
  output crv_pkg::frame_t      rd_frm,
  output logic                 avail,
  input  wire logic            pop
);

  crv_pkg::frame_t slot_r [2];
  logic            wptr_r, rptr_r;
  logic [1:0]      count_r;

  assign full   = count_r == 2'd2;
  assign avail  = count_r != 2'd0;
  assign rd_frm = slot_r[rptr_r];

  // store a frame on push
  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wptr_r] <= wr_frm;
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push && !full) wptr_r <= ~wptr_r;
      if (pop && avail) rptr_r <= ~rptr_r;
      count_r <= count_r + 2'(push && !full) - 2'(pop && avail);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/crv_back.sv
// ---------------------------------------------------------------------------
// crv_back
// Point generation: CORDIC per point, in-plane combine, radius scale,
// saturating add to the center, output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "circle_ring_vertices_macros.svh"

module crv_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire crv_pkg::frame_t frm,
  input  wire logic            frm_avail,
  output logic                 frm_pop,
  crv_pt_if.source             pt
);

  crv_pkg::back_state_t state_r, state_nxt;
  crv_pkg::frame_t      f_r;
  logic [5:0]           idx_r;
  logic [31:0]          phase_r;
  logic [6:0]           prem_r;
  logic signed [33:0]   x_r, y_r, z_r;
  logic                 flip_r;
  logic [4:0]           step_r;
  logic [3:0]           cnt_r;
  logic signed [67:0]   acc_r, prod_r;
  logic signed [33:0]   w_r [3];
  logic signed [31:0]   pt_r [3];
  logic                 out_valid_r;
  logic signed [31:0]   out_x_r, out_y_r, out_z_r;
  logic [5:0]           out_idx_r;
  logic                 out_last_r;

  logic               out_load;
  logic               last;
  logic [7:0]         rem_sum;
  logic               carry;
  logic [31:0]        phase_n;
  logic [6:0]         prem_n;
  logic signed [33:0] dx, dy, at;
  logic signed [33:0] cval, sval, mul_a, mul_b;
  logic signed [31:0] pt_val;

  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    logic signed [31:0] r;
    if (v > 39'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -39'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  // phase of the next point, kept as quotient plus remainder
  always_comb begin
    last    = {1'b0, idx_r} == f_r.segs - 7'd1;
    rem_sum = {1'b0, prem_r} + {1'b0, f_r.step_rem};
    carry   = rem_sum >= {1'b0, f_r.segs};
    phase_n = phase_r + {1'b0, f_r.step_q} + 32'(carry);
    prem_n  = carry ? 7'(rem_sum - {1'b0, f_r.segs}) : rem_sum[6:0];
  end

  // rotation step and combine operands
  always_comb begin
    dx    = y_r >>> step_r;
    dy    = x_r >>> step_r;
    at    = $signed({2'b00, crv_pkg::atan_turn(step_r)});
    cval  = flip_r ? -x_r : x_r;
    sval  = flip_r ? -y_r : y_r;
    mul_a = 34'sd0;
    mul_b = 34'sd0;
    if (state_r == crv_pkg::B_MAC) begin
      case (cnt_r)
        4'd0: begin mul_a = cval; mul_b = 34'($signed(f_r.u[0])); end
        4'd1: begin mul_a = sval; mul_b = 34'($signed(f_r.v[0])); end
        4'd2: begin mul_a = cval; mul_b = 34'($signed(f_r.u[1])); end
        4'd3: begin mul_a = sval; mul_b = 34'($signed(f_r.v[1])); end
        4'd4: begin mul_a = cval; mul_b = 34'($signed(f_r.u[2])); end
        4'd5: begin mul_a = sval; mul_b = 34'($signed(f_r.v[2])); end
        4'd7: begin mul_a = $signed({3'b000, f_r.radius}); mul_b = w_r[0]; end
        4'd8: begin mul_a = $signed({3'b000, f_r.radius}); mul_b = w_r[1]; end
        4'd9: begin mul_a = $signed({3'b000, f_r.radius}); mul_b = w_r[2]; end
        default: begin mul_a = 34'sd0; mul_b = 34'sd0; end
      endcase
    end
    case (cnt_r)
      4'd8:    pt_val = sat32(39'(crv_pkg::round_q30(prod_r)) + 39'($signed(f_r.ctr[0])));
      4'd9:    pt_val = sat32(39'(crv_pkg::round_q30(prod_r)) + 39'($signed(f_r.ctr[1])));
      default: pt_val = sat32(39'(crv_pkg::round_q30(prod_r)) + 39'($signed(f_r.ctr[2])));
    endcase
  end

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    frm_pop   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      crv_pkg::B_IDLE: begin
        if (frm_avail) begin
          frm_pop   = 1'b1;
          state_nxt = crv_pkg::B_ROT;
        end
      end
      crv_pkg::B_ROT: begin
        if (step_r == 5'd29) state_nxt = crv_pkg::B_MAC;
      end
      crv_pkg::B_MAC: begin
        if (cnt_r == 4'd10) state_nxt = crv_pkg::B_OUT;
      end
      crv_pkg::B_OUT: begin
        if (!out_valid_r || pt.ready) begin
          out_load  = 1'b1;
          state_nxt = last ? crv_pkg::B_IDLE : crv_pkg::B_ROT;
        end
      end
      default: state_nxt = crv_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crv_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (pt.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      crv_pkg::B_IDLE: begin
        if (frm_avail) begin
          f_r     <= frm;
          idx_r   <= 6'd0;
          phase_r <= 32'd0;
          prem_r  <= 7'd0;
          x_r     <= crv_pkg::CORDIC_GAIN;
          y_r     <= 34'sd0;
          z_r     <= 34'sd0;
          flip_r  <= 1'b0;
          step_r  <= 5'd0;
        end
      end
      crv_pkg::B_ROT: begin
        if (!z_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        step_r <= step_r + 5'd1;
        cnt_r  <= 4'd0;
      end
      crv_pkg::B_MAC: begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd1 || cnt_r == 4'd3 || cnt_r == 4'd5) acc_r <= prod_r;
        if (cnt_r == 4'd2) w_r[0] <= 34'(crv_pkg::round_q30(acc_r + prod_r));
        if (cnt_r == 4'd4) w_r[1] <= 34'(crv_pkg::round_q30(acc_r + prod_r));
        if (cnt_r == 4'd6) w_r[2] <= 34'(crv_pkg::round_q30(acc_r + prod_r));
        if (cnt_r == 4'd8) pt_r[0] <= pt_val;
        if (cnt_r == 4'd9) pt_r[1] <= pt_val;
        if (cnt_r == 4'd10) pt_r[2] <= pt_val;
      end
      crv_pkg::B_OUT: begin
        if (out_load) begin
          out_x_r    <= pt_r[0];
          out_y_r    <= pt_r[1];
          out_z_r    <= pt_r[2];
          out_idx_r  <= idx_r;
          out_last_r <= last;
          // set up the rotation for the next point
          idx_r   <= idx_r + 6'd1;
          phase_r <= phase_n;
          prem_r  <= prem_n;
          x_r     <= crv_pkg::CORDIC_GAIN;
          y_r     <= 34'sd0;
          z_r     <= $signed({{3{phase_n[30]}}, phase_n[30:0]});
          flip_r  <= phase_n[31] ^ phase_n[30];
          step_r  <= 5'd0;
        end
      end
      default: begin
      end
    endcase
  end

  assign pt.valid       = out_valid_r;
  assign pt.point_x     = out_x_r;
  assign pt.point_y     = out_y_r;
  assign pt.point_z     = out_z_r;
  assign pt.point_index = out_idx_r;
  assign pt.last_point  = out_last_r;

  `CRV_ASSERT_IMP(a_pop_needs_frame, frm_pop, frm_avail)
  `CRV_ASSERT_IMP(a_load_when_free, out_load, !out_valid_r || pt.ready)
  `CRV_ASSERT_IMP(a_index_in_ring, state_r == crv_pkg::B_OUT, {1'b0, idx_r} < f_r.segs)
  `CRV_ASSERT_NXT(a_rot_to_mac, state_r == crv_pkg::B_ROT && step_r == 5'd29,
                  state_r == crv_pkg::B_MAC)

endmodule

`default_nettype wire

// File: rtl/core/circle_ring_vertices.sv
// ---------------------------------------------------------------------------
// circle_ring_vertices
// Points evenly spaced on a circle in 3-D space, one result per point.
// ---------------------------------------------------------------------------
// in_req carries one ring request (center, normal, radius, segment count);
// out_pt returns its points in order from index 0, last_point on the final.
// The count is forced into 3..MAX_SEGMENTS; a zero normal repeats the center.
// Setup per request: three normalizations (sum of squares, square root, three
// divisions, a step to advance), a cross product, a phase step division and
// a step to queue the frame.
// in_req.ready is high only while setup is idle.
// Each point runs 30 CORDIC rotations, then its work on the shared
// multiplier, then a load of the output register. Setup overlaps the points of
// the previous ring through a two-entry queue.
// Reset (rst_n low, synchronous) empties the queue and drops any ring in
// flight. When out_pt.ready is low the point waits in the output register and
// point generation pauses; setup then stops once the queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module circle_ring_vertices #(
  parameter logic [6:0] MAX_SEGMENTS = crv_pkg::MAX_SEGMENTS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  crv_req_if.sink   in_req,
  crv_pt_if.source  out_pt
);

  crv_pkg::frame_t push_frm, pop_frm;
  logic            push, full, avail, pop;

  crv_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_req),
    .frm       (push_frm),
    .frm_valid (push),
    .frm_full  (full)
  );

  crv_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_frm (push_frm),
    .push   (push),
    .full   (full),
    .rd_frm (pop_frm),
    .avail  (avail),
    .pop    (pop)
  );

  crv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm       (pop_frm),
    .frm_avail (avail),
    .frm_pop   (pop),
    .pt        (out_pt)
  );

endmodule

`default_nettype wire

// File: bench/circle_ring_vertices_tb.sv
// ---------------------------------------------------------------------------
// circle_ring_vertices_tb
// Self-checking bench: drives ring requests and checks every generated point
// against an integer predictor of the normalization, cross-product and
// CORDIC arithmetic, with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module circle_ring_vertices_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] cx, cy, cz, nx, ny, nz;
    logic [30:0]        radius;
    logic [6:0]         segs;
  } ring_req_t;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic [5:0]         idx;
    logic               last;
  } ring_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  crv_req_if req_ch ();
  crv_pt_if  pt_ch ();

  circle_ring_vertices dut (.clk(clk), .rst_n(rst_n), .in_req(req_ch.sink),
                            .out_pt(pt_ch.source));

  ring_req_t pending_reqs[$];
  ring_pt_t  expected_pts[$];
  int        fail_cnt = 0;
  bit        stim_done = 1'b0;
  longint    cycle_cnt = 0;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // floor of a / 2^k
  function automatic longint floor_shr(longint a, int k);
    return a >>> k;
  endfunction

  function automatic longint rnd30(longint a);
    return (a + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint rnd30_wide(logic signed [95:0] a);
    logic signed [95:0] t;
    t = (a + (96'sd1 <<< 29)) >>> 30;
    return longint'(t);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // append a request to the pending queue
  function automatic void add_req(ring_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // scale a vector to Q30 unit length; zero stays zero
  task automatic to_unit(input longint c[3], output longint o[3]);
    longint unsigned mag[3];
    longint unsigned sum, len;
    logic [95:0] num;
    longint q;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (c[k] < 0) ? -c[k] : c[k];
      if (mag[k] > 64'h80000000) mag[k] = 64'h80000000;
      sum += mag[k] * mag[k];
    end
    len = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = 0;
      if (len != 0) begin
        num = ({32'd0, mag[k]} << 30) + (len >> 1);
        q = longint'(num / len);
      end
      o[k] = (c[k] < 0) ? -q : q;
    end
  endtask

  task automatic cross30(input longint a[3], input longint b[3], output longint o[3]);
    o[0] = rnd30(a[1] * b[2] - a[2] * b[1]);
    o[1] = rnd30(a[2] * b[0] - a[0] * b[2]);
    o[2] = rnd30(a[0] * b[1] - a[1] * b[0]);
  endtask

  task automatic rotate(input logic [31:0] phase, output longint c, output longint s);
    logic [1:0] quad;
    bit flip;
    longint x, y, z, dx, dy;
    quad = phase[31:30];
    flip = (quad == 2'd1) || (quad == 2'd2);
    if (flip) phase = phase - 32'h80000000;
    z = longint'($signed(phase));
    x = crv_pkg::CORDIC_GAIN;
    y = 0;
    for (int k = 0; k < 30; k++) begin
      dx = floor_shr(y, k);
      dy = floor_shr(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(crv_pkg::atan_turn(5'(k)));
      end else begin
        x += dx; y -= dy; z += longint'(crv_pkg::atan_turn(5'(k)));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[31:0];
  endfunction

  // expand one ring request into its points
  task automatic predict_ring(input ring_req_t r);
    longint ctr[3], raw[3], n[3], ax[3], tmp[3], u[3], v[3];
    longint c, s, w, off, segs;
    ring_pt_t p;
    logic [63:0] ph;
    ctr = '{longint'(r.cx), longint'(r.cy), longint'(r.cz)};
    raw = '{longint'(r.nx), longint'(r.ny), longint'(r.nz)};
    segs = r.segs;
    if (segs < 3) segs = 3;
    if (segs > 64) segs = 64;
    to_unit(raw, n);
    ax = '{0, 0, 0};
    if (((n[0] < 0) ? -n[0] : n[0]) < longint'(crv_pkg::NINE_TENTHS))
      ax[0] = crv_pkg::ONE_Q30;
    else ax[1] = crv_pkg::ONE_Q30;
    cross30(n, ax, tmp);
    to_unit(tmp, u);
    cross30(n, u, tmp);
    to_unit(tmp, v);
    for (longint i = 0; i < segs; i++) begin
      ph = (64'(i) << 32) / 64'(segs);
      rotate(ph[31:0], c, s);
      for (int k = 0; k < 3; k++) begin
        w = rnd30(c * u[k] + s * v[k]);
        off = rnd30_wide(96'(longint'(r.radius)) * 96'(w));
        if (k == 0) p.px = clamp32(ctr[k] + off);
        if (k == 1) p.py = clamp32(ctr[k] + off);
        if (k == 2) p.pz = clamp32(ctr[k] + off);
      end
      p.idx = 6'(i);
      p.last = (i == segs - 1);
      expected_pts.insert(expected_pts.size(), p);
    end
  endtask

  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 131072)) - 65536);
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic ring_req_t random_req();
    ring_req_t r;
    r.cx = rand32(); r.cy = rand32(); r.cz = rand32();
    r.nx = rand32(); r.ny = rand32(); r.nz = rand32();
    if ($urandom_range(0, 9) == 0) begin
      r.nx = 0; r.ny = 0; r.nz = 0;
    end
    r.radius = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
    if ($urandom_range(0, 7) == 0) r.segs = 7'($urandom_range(0, 127));
    else if ($urandom_range(0, 7) == 0) r.segs = 7'($urandom_range(0, 64));
    else r.segs = 7'($urandom_range(0, 12));
    return r;
  endfunction

  function automatic ring_req_t mk(logic signed [31:0] c, logic signed [31:0] nx,
                                   logic signed [31:0] ny, logic signed [31:0] nz,
                                   logic [30:0] rad, logic [6:0] sg);
    ring_req_t r;
    r.cx = c; r.cy = c; r.cz = c;
    r.nx = nx; r.ny = ny; r.nz = nz;
    r.radius = rad; r.segs = sg;
    return r;
  endfunction

  // fill the request queue: directed rings, then random
  initial begin
    add_req(mk(0, 0, 0, 32'h10000, 31'h10000, 7'd0));
    add_req(mk(0, 32'h10000, 0, 0, 31'h10000, 7'd1));
    add_req(mk(32'h50000, 0, 32'h10000, 0, 31'h20000, 7'd2));
    add_req(mk(0, 0, 0, 0, 31'h7FFFFFFF, 7'd4));
    add_req(mk(32'h7FFFFFFF, 1, 1, 1, 31'h7FFFFFFF, 7'd64));
    add_req(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               31'h7FFFFFFF, 7'd127));
    add_req(mk(32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               31'h0, 7'd65));
    add_req(mk(-32'sd5, -32'sd58982, 32'sd28000, 0, 31'h30000, 7'd6));
    add_req(mk(32'h12345678, 32'sd58000, 32'sd25000, 0, 31'h4000, 7'd5));
    add_req(mk(32'sd100, 32'h80000000, 0, 0, 31'h7FFFFFFF, 7'd8));
    add_req(mk(32'sd100, 32'h7FFFFFFF, 0, 0, 31'h1, 7'd3));
    for (int i = 0; i < 169; i++) add_req(random_req());
  end

  // request driver
  int send_gap = 0;
  int sent_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold request until taken
    end else begin
      if (req_ch.valid) begin
        predict_ring(pending_reqs.pop_front());
        sent_cnt++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if ((sent_cnt == 11 || sent_cnt == 100) && expected_pts.size() != 0) begin
        // drain every outstanding point before the next request
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        ring_req_t r;
        r = pending_reqs[0];
        req_ch.valid <= 1'b1;
        req_ch.center_x <= r.cx; req_ch.center_y <= r.cy; req_ch.center_z <= r.cz;
        req_ch.normal_x <= r.nx; req_ch.normal_y <= r.ny; req_ch.normal_z <= r.nz;
        req_ch.radius <= r.radius; req_ch.segment_count <= r.segs;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      end else begin
        req_ch.valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.center_x = 0; req_ch.center_y = 0; req_ch.center_z = 0;
    req_ch.normal_x = 0; req_ch.normal_y = 0; req_ch.normal_z = 0;
    req_ch.radius = 0; req_ch.segment_count = 0;
    pt_ch.ready = 1'b0;
  end

  // point monitor with random stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      pt_ch.ready <= 1'b0;
    end else begin
      if (pt_ch.valid && pt_ch.ready) begin
        if (expected_pts.size() == 0) begin
          $error("unexpected point index %0d", pt_ch.point_index);
          fail_cnt++;
        end else begin
          ring_pt_t e;
          e = expected_pts.pop_front();
          if (pt_ch.point_x !== e.px) begin
            $error("point_x expected %0d actual %0d", e.px, pt_ch.point_x); fail_cnt++;
          end
          if (pt_ch.point_y !== e.py) begin
            $error("point_y expected %0d actual %0d", e.py, pt_ch.point_y); fail_cnt++;
          end
          if (pt_ch.point_z !== e.pz) begin
            $error("point_z expected %0d actual %0d", e.pz, pt_ch.point_z); fail_cnt++;
          end
          if (pt_ch.point_index !== e.idx) begin
            $error("point_index expected %0d actual %0d", e.idx, pt_ch.point_index);
            fail_cnt++;
          end
          if (pt_ch.last_point !== e.last) begin
            $error("last_point expected %0d actual %0d", e.last, pt_ch.last_point);
            fail_cnt++;
          end
        end
        stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
        pt_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        pt_ch.ready <= 1'b0;
      end else begin
        pt_ch.ready <= 1'b1;
      end
    end
  end

  // reset, drain and verdict
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && !req_ch.valid && expected_pts.size() == 0);
    repeat (600) @(posedge clk);
    if (fail_cnt == 0 && expected_pts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == 64'd3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

`default_nettype wire
